// ----- design/fqc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqc_pkg
// Shared types and constants for the FIFO queue with cancel.
// ----------------------------------------------------------------------------
package fqc_pkg;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 32;
    localparam int FILL_BITS   = $clog2(DEPTH + 1);
    localparam int IDX_BITS    = $clog2(DEPTH);

    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;
    localparam logic [1:0] FUNC_PEEK   = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]             func;
        logic [HANDLE_BITS-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] head_value;
        logic [FILL_BITS-1:0]   fill_count;
        logic                   is_empty;
    } res_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } fsm_state_t;

    typedef struct packed {
        logic load_req;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/fqc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqc_ctrl
// Sequencer: captures one request, then executes it once the output
// register is free.
// ----------------------------------------------------------------------------
module fqc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  fqc_pkg::dp_status_t    dp_status,
    output fqc_pkg::ctrl_cmd_t     cmd
);
    import fqc_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.load_req = 1'b0;
        cmd.exec     = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (dp_status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

// ----- design/fqc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqc_dpath
// Row of handle cells with parallel compare, gap-closing shift, fill count
// and the registered result.
// ----------------------------------------------------------------------------
module fqc_dpath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fqc_pkg::req_t          s_req,
    input  fqc_pkg::ctrl_cmd_t     cmd,
    output fqc_pkg::dp_status_t    dp_status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output fqc_pkg::res_t          m_res
);
    import fqc_pkg::*;

    req_t                   req_reg;
    logic [HANDLE_BITS-1:0] cells_reg  [DEPTH];
    logic [HANDLE_BITS-1:0] cells_next [DEPTH];
    logic [FILL_BITS-1:0]   count_reg;
    logic [FILL_BITS-1:0]   count_next;
    res_t                   res_reg;
    res_t                   res_next;
    logic                   valid_reg;

    logic [HANDLE_BITS-1:0] h;
    logic                   h_zero;
    logic                   q_empty;
    logic                   q_full;
    logic [DEPTH-1:0]       match;
    logic [DEPTH-1:0]       shift_mask;
    logic [DEPTH-1:0]       wr_sel;
    logic                   found;
    logic                   do_shift;
    logic                   do_write;

    assign h       = req_reg.handle;
    assign h_zero  = (h == '0);
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == FILL_BITS'(DEPTH));
    assign found   = |match;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i]  = (FILL_BITS'(i) < count_reg) && (cells_reg[i] == h);
            wr_sel[i] = (count_reg == FILL_BITS'(i));
        end
    end

    // shift every cell at or after the oldest match
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            shift_mask[i] = 1'b0;
            for (int j = 0; j < DEPTH; j++) begin
                if (j <= i && match[j]) begin
                    shift_mask[i] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        do_shift            = 1'b0;
        do_write            = 1'b0;
        count_next          = count_reg;
        res_next.status     = STATUS_OK;
        res_next.head_value = '0;
        unique case (req_reg.func)
            FUNC_PUSH: begin
                if (h_zero) begin
                    res_next.status = STATUS_INVALID;
                end else if (q_full) begin
                    res_next.status = STATUS_FULL;
                end else begin
                    do_write   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_POP: begin
                if (q_empty) begin
                    res_next.status = STATUS_EMPTY;
                end else begin
                    res_next.head_value = cells_reg[0];
                    do_shift            = 1'b1;
                    count_next          = count_reg - 1'b1;
                end
            end
            FUNC_CANCEL: begin
                if (h_zero) begin
                    res_next.status = STATUS_INVALID;
                end else if (!found) begin
                    res_next.status = STATUS_EMPTY;
                end else begin
                    do_shift   = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            FUNC_PEEK: begin
                if (q_empty) begin
                    res_next.status = STATUS_EMPTY;
                end else begin
                    res_next.head_value = cells_reg[0];
                end
            end
            default: begin
                res_next.status = STATUS_OK;
            end
        endcase
        res_next.fill_count = count_next;
        res_next.is_empty   = (count_next == '0);
    end

    // pop shifts the whole row; cancel only from the match onward
    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            cells_next[i] = cells_reg[i];
            if (do_shift && (shift_mask[i] || req_reg.func == FUNC_POP)) begin
                cells_next[i] = cells_reg[i + 1];
            end
            if (do_write && wr_sel[i]) begin
                cells_next[i] = h;
            end
        end
        cells_next[DEPTH-1] = cells_reg[DEPTH-1];
        if (do_write && wr_sel[DEPTH-1]) begin
            cells_next[DEPTH-1] = h;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_req;
        end
        if (cmd.exec) begin
            cells_reg <= cells_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign dp_status.out_free = !valid_reg || m_ready;
    assign m_valid            = valid_reg;
    assign m_res              = res_reg;

endmodule

// ----- design/fifo_queue_with_cancel_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_cancel_top
// Bounded FIFO of nonzero handles with push, pop, cancel-by-value and peek.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_req carries one request: func (push, pop, cancel,
//   peek) and a handle. m_valid/m_ready/m_res returns exactly one result
//   per request: status, popped or head handle, fill count, empty flag.
//   A request is taken into an input register on acceptance; the execute
//   step then compares the handle against every cell at once, shifts the
//   row to close a gap and loads the output register.
//   A new request is accepted only after the previous one has executed,
//   a limit set by the capture/execute sequence of the controller.
//   s_ready stays low in the execute state; while a result waits on a stalled
//   receiver a new request is still accepted, but its execute cycle waits
//   until the output register is taken.
//   Reset (aresetn low, synchronous) empties the queue and drops m_valid;
//   cell contents are not cleared, only the fill count.
// ----------------------------------------------------------------------------
module fifo_queue_with_cancel_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fqc_pkg::req_t   s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output fqc_pkg::res_t   m_res
);
    import fqc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    fqc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    fqc_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_req     (s_req),
        .cmd       (cmd),
        .dp_status (dp_status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

endmodule

// ----- design/fqc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqc_checker
// Port-level checks for the FIFO queue with cancel, bound to the top level.
// ----------------------------------------------------------------------------
module fqc_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  fqc_pkg::req_t   s_req,
    input  logic            m_valid,
    input  logic            m_ready,
    input  fqc_pkg::res_t   m_res
);
    import fqc_pkg::*;

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_res.is_empty == (m_res.fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_req))
        else $error("request changed while waiting");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.status == STATUS_FULL
            |-> m_res.fill_count == FILL_BITS'(DEPTH))
        else $error("full status without full queue");

    a_no_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_res.status == STATUS_INVALID || m_res.status == STATUS_EMPTY
            || m_res.status == STATUS_FULL) |-> m_res.head_value == '0)
        else $error("head value on failed request");

endmodule

bind fifo_queue_with_cancel_top fqc_checker u_fqc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_res   (m_res)
);

// ----- verif/fifo_queue_with_cancel_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_cancel_top_test
// Self-checking bench for the handle queue with push, pop, cancel and peek.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty, invalid and cancel
// corners. Random traffic follows, switching between fill and drain phases
// so the queue reaches both full and empty. A model predicts each result
// except typed rows, which hold their own. All are compared field by field
// in order. Both channels idle at random, save one long gapless stretch.
// ----------------------------------------------------------------------------
module fifo_queue_with_cancel_top_test;

    import fqc_pkg::*;

    localparam int RANDOM_REQS = 700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 24;

    typedef struct packed {
        req_t req;
        logic typed;
        res_t want;
    } dir_row_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req   = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_res;

    logic [HANDLE_BITS-1:0] held_handles[$];
    res_t                   pending_results[$];
    int                     mismatches = 0;
    int                     requests   = 0;
    int                     results    = 0;
    int                     status_seen[4] = '{0, 0, 0, 0};
    int                     cycles     = 0;
    bit                     gaps_on    = 1'b1;

    dir_row_t plan [DIR_ROWS] = '{
        '{'{FUNC_POP,    32'h0},        1'b1, '{STATUS_EMPTY,   32'h0, 5'd0, 1'b1}},
        '{'{FUNC_PEEK,   32'h0},        1'b1, '{STATUS_EMPTY,   32'h0, 5'd0, 1'b1}},
        '{'{FUNC_CANCEL, 32'h5},        1'b1, '{STATUS_EMPTY,   32'h0, 5'd0, 1'b1}},
        '{'{FUNC_PUSH,   32'h0},        1'b1, '{STATUS_INVALID, 32'h0, 5'd0, 1'b1}},
        '{'{FUNC_CANCEL, 32'h0},        1'b1, '{STATUS_INVALID, 32'h0, 5'd0, 1'b1}},
        '{'{FUNC_PUSH,   32'hFFFFFFFF}, 1'b1, '{STATUS_OK,      32'h0, 5'd1, 1'b0}},
        '{'{FUNC_PEEK,   32'h0},        1'b1, '{STATUS_OK, 32'hFFFFFFFF, 5'd1, 1'b0}},
        '{'{FUNC_PUSH,   32'h7},        1'b0, '0},
        '{'{FUNC_PUSH,   32'h1},        1'b0, '0},
        '{'{FUNC_PUSH,   32'h7},        1'b0, '0},
        '{'{FUNC_PUSH,   32'h80000000}, 1'b0, '0},
        '{'{FUNC_CANCEL, 32'h7},        1'b0, '0},
        '{'{FUNC_CANCEL, 32'h12345678}, 1'b0, '0},
        '{'{FUNC_PUSH,   32'h0},        1'b0, '0},
        '{'{FUNC_PEEK,   32'hFFFFFFFF}, 1'b0, '0},
        '{'{FUNC_POP,    32'h0},        1'b0, '0},
        '{'{FUNC_POP,    32'hFFFFFFFF}, 1'b0, '0},
        '{'{FUNC_POP,    32'h0},        1'b0, '0},
        '{'{FUNC_POP,    32'h0},        1'b0, '0},
        '{'{FUNC_POP,    32'h0},        1'b0, '0},
        '{'{FUNC_PUSH,   32'h55555555}, 1'b0, '0},
        '{'{FUNC_PUSH,   32'hAAAAAAAA}, 1'b0, '0},
        '{'{FUNC_CANCEL, 32'hAAAAAAAA}, 1'b0, '0},
        '{'{FUNC_POP,    32'h0},        1'b0, '0}
    };

    fifo_queue_with_cancel_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Queue model: applies one request and returns the result it produces.
    function automatic res_t predict_queue_op(req_t r);
        res_t res;
        int   idx;
        idx = -1;
        res = '0;
        res.status = STATUS_OK;
        case (r.func)
            FUNC_PUSH: begin
                if (r.handle == '0)
                    res.status = STATUS_INVALID;
                else if (held_handles.size() >= DEPTH)
                    res.status = STATUS_FULL;
                else
                    held_handles.push_back(r.handle);
            end
            FUNC_POP: begin
                if (held_handles.size() == 0)
                    res.status = STATUS_EMPTY;
                else
                    res.head_value = held_handles.pop_front();
            end
            FUNC_CANCEL: begin
                if (r.handle == '0) begin
                    res.status = STATUS_INVALID;
                end else begin
                    for (int i = 0; i < held_handles.size(); i++) begin
                        if (idx < 0 && held_handles[i] == r.handle)
                            idx = i;
                    end
                    if (idx >= 0)
                        held_handles.delete(idx);
                    else
                        res.status = STATUS_EMPTY;
                end
            end
            default: begin
                if (held_handles.size() == 0)
                    res.status = STATUS_EMPTY;
                else
                    res.head_value = held_handles[0];
            end
        endcase
        res.fill_count = FILL_BITS'(held_handles.size());
        res.is_empty   = (held_handles.size() == 0);
        return res;
    endfunction

    // Small values 40% of the time, so duplicates and cancel hits are common.
    function automatic logic [HANDLE_BITS-1:0] random_handle();
        int k;
        k = $urandom_range(0, 99);
        if (k < 5)
            return '0;
        else if (k < 45)
            return HANDLE_BITS'($urandom_range(1, 6));
        else if (k < 55)
            return {HANDLE_BITS{1'b1}} - HANDLE_BITS'($urandom_range(0, 3));
        else
            return HANDLE_BITS'($urandom);
    endfunction

    task automatic report_mismatch(string what, logic [HANDLE_BITS-1:0] got,
                                   logic [HANDLE_BITS-1:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH @%0t result %0d %s: got %0h expected %0h",
                     $time, results, what, got, want);
    endtask

    task automatic check_result(res_t got);
        res_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", got.head_value, '0);
        end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", HANDLE_BITS'(got.status),
                                HANDLE_BITS'(want.status));
            if (got.head_value !== want.head_value)
                report_mismatch("head_value", got.head_value, want.head_value);
            if (got.fill_count !== want.fill_count)
                report_mismatch("fill_count", HANDLE_BITS'(got.fill_count),
                                HANDLE_BITS'(want.fill_count));
            if (got.is_empty !== want.is_empty)
                report_mismatch("is_empty", HANDLE_BITS'(got.is_empty),
                                HANDLE_BITS'(want.is_empty));
        end
        status_seen[got.status]++;
        results++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_result(m_res);
            m_ready <= !(gaps_on && $urandom_range(0, 99) < 9);
        end
    end

    // Leaves s_valid high; the caller lowers it for a gap and after the last request.
    task automatic send_request(req_t r, logic typed, res_t want);
        res_t pred;
        s_req   <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pred = predict_queue_op(r);
        pending_results.push_back(typed ? want : pred);
        requests++;
    endtask

    task automatic maybe_idle();
        if (gaps_on && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    initial begin
        req_t r;
        int   w;
        bit   filling;
        filling = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            maybe_idle();
            send_request(plan[i].req, plan[i].typed, plan[i].want);
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            gaps_on = !(n >= 250 && n < 450);
            if (held_handles.size() >= DEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (held_handles.size() == 0 && $urandom_range(0, 1) == 0)
                filling = 1'b1;
            w = $urandom_range(0, 99);
            r.handle = HANDLE_BITS'($urandom);
            if (filling)
                r.func = (w < 60) ? FUNC_PUSH : (w < 75) ? FUNC_POP :
                         (w < 90) ? FUNC_CANCEL : FUNC_PEEK;
            else
                r.func = (w < 20) ? FUNC_PUSH : (w < 60) ? FUNC_POP :
                         (w < 90) ? FUNC_CANCEL : FUNC_PEEK;
            if (r.func == FUNC_PUSH) begin
                r.handle = random_handle();
            end else if (r.func == FUNC_CANCEL) begin
                if (held_handles.size() != 0 && $urandom_range(0, 99) < 60)
                    r.handle = held_handles[$urandom_range(0, held_handles.size() - 1)];
                else
                    r.handle = random_handle();
            end
            maybe_idle();
            send_request(r, 1'b0, '0);
        end
        gaps_on = 1'b1;
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d requests in %0d cycles, %0d results checked, %0d mismatches",
                 requests, cycles, results, mismatches);
        $display("Status mix: ok %0d, empty/no match %0d, full %0d, invalid %0d",
                 status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
                 status_seen[STATUS_FULL], status_seen[STATUS_INVALID]);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
